[hdl/rfa_pkg.sv]
// Shared types, constants and helpers for the reply frame assembler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rfa_pkg;

    localparam int BYTE_W         = 8;
    localparam int WORD_W         = 32;
    localparam int HALF_W         = 16;
    localparam int COUNT_W        = 6;
    localparam int LEN_W          = 9;
    localparam int MAX_DATA_WORDS = 63;

    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] HEADER_BYTES     = 8'd11;
    localparam logic [BYTE_W-1:0] START_CHAR       = 8'h68;
    localparam logic [BYTE_W-1:0] END_CHAR         = 8'h16;
    localparam logic [BYTE_W-1:0] HOP_RESET        = 8'd13;
    localparam logic [BYTE_W-1:0] MAX_LENGTH_RESET = 8'd255;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOP_INITIAL = 2'd1;

    // item kinds
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // output job: up to four header words plus trailer
    localparam int JOB_WORDS = 5;
    localparam int JOB_IDX_W = $clog2(JOB_WORDS);

    localparam logic [JOB_IDX_W-1:0] IDX_FIRST        = 3'd0;
    localparam logic [JOB_IDX_W-1:0] IDX_DATA_TRAILER = 3'd1;
    localparam logic [JOB_IDX_W-1:0] IDX_HDR_LAST     = 3'd3;
    localparam logic [JOB_IDX_W-1:0] IDX_HDR_TRAILER  = 3'd4;

    typedef struct packed {
        logic                command;
        logic [BYTE_W-1:0]   control_field;
        logic [BYTE_W-1:0]   dest_subaddress;
        logic [HALF_W-1:0]   message_type;
        logic [HALF_W-1:0]   received_source;
        logic [HALF_W-1:0]   received_dest;
        logic [HALF_W-1:0]   sequence_number;
        logic [COUNT_W-1:0]  data_word_count;
        logic [WORD_W-1:0]   data_word;
    } rfa_item_t;

    typedef struct packed {
        logic [JOB_WORDS-1:0][WORD_W-1:0] words;
        logic [JOB_IDX_W-1:0]             last_idx;
        logic                             trailer;
        logic                             error;
    } rfa_job_t;

    // modulo-256 sum of the four bytes of a word
    function automatic logic [BYTE_W-1:0] byte_sum(input logic [WORD_W-1:0] w);
        return w[7:0] + w[15:8] + w[23:16] + w[31:24];
    endfunction

    function automatic logic [WORD_W-1:0] trailer_word(input logic [BYTE_W-1:0] cs);
        return {{(WORD_W-2*BYTE_W){1'b0}}, END_CHAR, cs};
    endfunction

endpackage

`default_nettype wire

[hdl/rfa_frame_ctrl.sv]
// Input register and frame state: builds the output job for each start beat and each data beat of an open frame.
// Depends on rfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfa_frame_ctrl
    import rfa_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire rfa_item_t         in_item,
    input  wire logic [BYTE_W-1:0] max_length,
    input  wire logic [BYTE_W-1:0] hop_initial,
    input  wire logic              job_free,
    output logic                   job_load,
    output rfa_job_t               job
);

    logic                 in_valid_reg, in_valid_next;
    rfa_item_t            item_reg;
    logic [COUNT_W-1:0]   words_remaining_reg, words_remaining_next;
    logic [BYTE_W-1:0]    running_checksum_reg, running_checksum_next;
    logic                 frame_active_reg, frame_active_next;

    logic                 in_moves;
    logic [LEN_W-1:0]     frame_len;
    logic                 oversize;
    logic [WORD_W-1:0]    w1, w2, w3, w4;
    logic [BYTE_W-1:0]    hdr_sum, data_sum;
    logic [COUNT_W-1:0]   remaining_dec;

    assign in_moves      = in_valid_reg && job_free;
    assign in_ready      = !in_valid_reg || job_free;
    assign in_valid_next = in_ready ? in_valid : in_valid_reg;

    assign frame_len = LEN_W'({item_reg.data_word_count, 2'b00}) + LEN_W'(HEADER_BYTES);
    assign oversize  = (frame_len > LEN_W'(max_length))
                    || (item_reg.data_word_count > COUNT_W'(MAX_DATA_WORDS));

    assign w1 = {frame_len[BYTE_W-1:0], frame_len[BYTE_W-1:0], START_CHAR, 8'h00};
    assign w2 = {item_reg.message_type[7:0], item_reg.dest_subaddress,
                 item_reg.control_field, START_CHAR};
    assign w3 = {item_reg.received_dest[7:0], item_reg.received_source,
                 item_reg.message_type[15:8]};
    assign w4 = {item_reg.sequence_number, hop_initial, item_reg.received_dest[15:8]};

    // sum starts at the control byte, so the start char of w2 is left out
    assign hdr_sum = item_reg.control_field + item_reg.dest_subaddress
                   + item_reg.message_type[7:0] + byte_sum(w3) + byte_sum(w4);
    assign data_sum      = running_checksum_reg + byte_sum(item_reg.data_word);
    assign remaining_dec = words_remaining_reg - COUNT_W'(1);

    always_comb
    begin
        words_remaining_next  = words_remaining_reg;
        running_checksum_next = running_checksum_reg;
        frame_active_next     = frame_active_reg;
        job_load              = 1'b0;
        job                   = '0;

        if (in_moves)
        begin
            if (item_reg.command == CMD_START)
            begin
                job_load = 1'b1;
                if (oversize)
                begin
                    words_remaining_next  = '0;
                    running_checksum_next = '0;
                    frame_active_next     = 1'b0;
                    job.last_idx          = IDX_FIRST;
                    job.error             = 1'b1;
                end
                else
                begin
                    job.words[0]          = w1;
                    job.words[1]          = w2;
                    job.words[2]          = w3;
                    job.words[3]          = w4;
                    running_checksum_next = hdr_sum;
                    if (item_reg.data_word_count == '0)
                    begin
                        // empty frame closes at once
                        job.words[4]         = trailer_word(hdr_sum);
                        job.last_idx         = IDX_HDR_TRAILER;
                        job.trailer          = 1'b1;
                        words_remaining_next = '0;
                        frame_active_next    = 1'b0;
                    end
                    else
                    begin
                        job.last_idx         = IDX_HDR_LAST;
                        words_remaining_next = item_reg.data_word_count;
                        frame_active_next    = 1'b1;
                    end
                end
            end
            else if (frame_active_reg)
            begin
                job_load              = 1'b1;
                job.words[0]          = item_reg.data_word;
                running_checksum_next = data_sum;
                words_remaining_next  = remaining_dec;
                if (remaining_dec == '0)
                begin
                    job.words[1]      = trailer_word(data_sum);
                    job.last_idx      = IDX_DATA_TRAILER;
                    job.trailer       = 1'b1;
                    frame_active_next = 1'b0;
                end
                else
                begin
                    job.last_idx = IDX_FIRST;
                end
            end
            // data while idle is dropped
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg         <= 1'b0;
            words_remaining_reg  <= '0;
            running_checksum_reg <= '0;
            frame_active_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg         <= in_valid_next;
            words_remaining_reg  <= words_remaining_next;
            running_checksum_reg <= running_checksum_next;
            frame_active_reg     <= frame_active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    // a frame is open exactly while data words are still owed
    a_active_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        frame_active_reg == (words_remaining_reg != '0))
        else $error("frame_active out of step with words_remaining");

endmodule

`default_nettype wire

[hdl/rfa_out_seq.sv]
// Output job register: sends the words of one job, one beat per cycle while out_ready is high.
// Depends on rfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfa_out_seq
    import rfa_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              job_load,
    input  wire rfa_job_t          job,
    output logic                   job_free,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [WORD_W-1:0]      out_word,
    output logic                   out_last,
    output logic                   out_error
);

    rfa_job_t              job_reg;
    logic                  job_valid_reg, job_valid_next;
    logic [JOB_IDX_W-1:0]  ptr_reg, ptr_next;
    logic                  at_last;
    logic                  beat_done;

    assign at_last   = (ptr_reg == job_reg.last_idx);
    assign beat_done = job_valid_reg && out_ready;
    assign job_free  = !job_valid_reg || (out_ready && at_last);

    assign out_valid = job_valid_reg;
    assign out_word  = job_reg.words[ptr_reg];
    assign out_last  = job_reg.trailer && at_last;
    assign out_error = job_reg.error;

    always_comb
    begin
        job_valid_next = job_valid_reg;
        ptr_next       = ptr_reg;
        if (job_load)
        begin
            job_valid_next = 1'b1;
            ptr_next       = IDX_FIRST;
        end
        else if (beat_done && at_last)
        begin
            job_valid_next = 1'b0;
        end
        else if (beat_done)
        begin
            ptr_next = ptr_reg + JOB_IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            ptr_reg       <= '0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            ptr_reg       <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            job_reg <= job;
        end
    end

    a_ptr_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg |-> ptr_reg <= job_reg.last_idx)
        else $error("word pointer ran past end of job");

    a_error_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid_reg && job_reg.error) |-> (!job_reg.trailer && job_reg.last_idx == IDX_FIRST))
        else $error("error job carries more than one beat");

endmodule

`default_nettype wire

[hdl/reply_frame_assembler.sv]
// An accepted beat waits in the input register until the output job register is free,
// then loads that register, which offers the job's first word on the output port.
// Throughput: one input beat per cycle while each yields one word and the output is
// ready; the single output port sets the rate: a start beat yields four words (five for
// an empty frame), the last data word two. Reset: idle, max_length 255, hop_initial 13.
// Depends on rfa_pkg, rfa_frame_ctrl and rfa_out_seq.
`timescale 1ns / 1ps
`default_nettype none

module reply_frame_assembler
    import rfa_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // control_field, dest_subaddress, message_type, received_source,
    // received_dest, sequence_number, data_word_count, data_word, zero pad
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
    // command
    input  wire logic [0:0]            s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // frame_word
    output logic [M_TDATA_W-1:0]       m_axis_tdata,
    output logic                       m_axis_tlast,
    // length_error
    output logic [0:0]                 m_axis_tuser,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [BYTE_W-1:0]     cfg_data
);

    logic [BYTE_W-1:0] max_length_reg;
    logic [BYTE_W-1:0] hop_initial_reg;
    rfa_item_t         item;
    rfa_job_t          job;
    logic              job_load;
    logic              job_free;
    logic              out_error;

    assign item.command         = s_axis_tuser[0];
    assign item.control_field   = s_axis_tdata[7:0];
    assign item.dest_subaddress = s_axis_tdata[15:8];
    assign item.message_type    = s_axis_tdata[31:16];
    assign item.received_source = s_axis_tdata[47:32];
    assign item.received_dest   = s_axis_tdata[63:48];
    assign item.sequence_number = s_axis_tdata[79:64];
    assign item.data_word_count = s_axis_tdata[85:80];
    assign item.data_word       = s_axis_tdata[117:86];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg  <= MAX_LENGTH_RESET;
            hop_initial_reg <= HOP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_LENGTH:  max_length_reg  <= cfg_data;
                CFG_HOP_INITIAL: hop_initial_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    rfa_frame_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_item     (item),
        .max_length  (max_length_reg),
        .hop_initial (hop_initial_reg),
        .job_free    (job_free),
        .job_load    (job_load),
        .job         (job)
    );

    rfa_out_seq u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_load  (job_load),
        .job       (job),
        .job_free  (job_free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_error (out_error)
    );

    assign m_axis_tuser[0] = out_error;

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        job_load |-> job_free)
        else $error("job loaded over one still being sent");

endmodule

`default_nettype wire

[bench/reply_frame_checker.sv]
// Scoreboard for the reply frame assembler: follows the input, output and
// register-write ports, predicts every frame beat and compares it in order.
// Depends on rfa_pkg for widths, characters and register indexes.
`timescale 1ns / 1ps

module reply_frame_checker
    import rfa_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic [0:0]            s_axis_tuser,
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [M_TDATA_W-1:0]  m_axis_tdata,
    input  wire logic                  m_axis_tlast,
    input  wire logic [0:0]            m_axis_tuser,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [BYTE_W-1:0]     cfg_data,
    output int                         fail_count,
    output int                         pending_beats
);

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
        logic              error;
    } frame_beat_t;

    frame_beat_t         frame_words_due[$];
    logic [BYTE_W-1:0]   limit_len;
    logic [BYTE_W-1:0]   hop_value;
    logic [BYTE_W-1:0]   checksum;
    logic [COUNT_W-1:0]  words_left;
    logic                in_frame;
    int                  mismatches = 0;
    int                  beats_seen = 0;

    task automatic report(input string what);
    begin
        // keep the log short if the block is badly broken
        if (mismatches < 40)
            $display("%0t ns: beat %0d: %s", $time, beats_seen, what);
        mismatches++;
    end
    endtask

    function automatic logic [BYTE_W-1:0] octet_sum(input logic [WORD_W-1:0] w);
        logic [BYTE_W-1:0] acc;
        acc = '0;
        for (int b = 0; b < WORD_W / BYTE_W; b++)
            acc += w[b*BYTE_W +: BYTE_W];
        return acc;
    endfunction

    task automatic push_beat(input logic [WORD_W-1:0] word, input logic last,
                             input logic error);
        frame_beat_t beat;
    begin
        beat.word  = word;
        beat.last  = last;
        beat.error = error;
        frame_words_due.push_back(beat);
    end
    endtask

    task automatic close_frame();
    begin
        push_beat({{(WORD_W-2*BYTE_W){1'b0}}, END_CHAR, checksum}, 1'b1, 1'b0);
        in_frame   = 1'b0;
        words_left = '0;
    end
    endtask

    task automatic assemble_reply(input logic cmd, input logic [S_TDATA_W-1:0] beat);
        logic [BYTE_W-1:0]  ctrl;
        logic [BYTE_W-1:0]  sub;
        logic [HALF_W-1:0]  mtype;
        logic [HALF_W-1:0]  src;
        logic [HALF_W-1:0]  dst;
        logic [HALF_W-1:0]  seq;
        logic [COUNT_W-1:0] count;
        logic [WORD_W-1:0]  data;
        logic [LEN_W-1:0]   len;
        logic [WORD_W-1:0]  w1, w2, w3, w4;
    begin
        ctrl  = beat[7:0];
        sub   = beat[15:8];
        mtype = beat[31:16];
        src   = beat[47:32];
        dst   = beat[63:48];
        seq   = beat[79:64];
        count = beat[85:80];
        data  = beat[117:86];
        if (cmd == CMD_START)
        begin
            len = {1'b0, count, 2'b00} + LEN_W'(HEADER_BYTES);
            if (len > {1'b0, limit_len} || int'(count) > MAX_DATA_WORDS)
            begin
                in_frame   = 1'b0;
                words_left = '0;
                checksum   = '0;
                push_beat('0, 1'b0, 1'b1);
            end
            else
            begin
                w1 = {len[7:0], len[7:0], START_CHAR, 8'h00};
                w2 = {mtype[7:0], sub, ctrl, START_CHAR};
                w3 = {dst[7:0], src, mtype[15:8]};
                w4 = {seq, hop_value, dst[15:8]};
                // sum starts at the control byte, so the start char is left out
                checksum = octet_sum({w2[31:8], 8'h00}) + octet_sum(w3) + octet_sum(w4);
                push_beat(w1, 1'b0, 1'b0);
                push_beat(w2, 1'b0, 1'b0);
                push_beat(w3, 1'b0, 1'b0);
                push_beat(w4, 1'b0, 1'b0);
                words_left = count;
                in_frame   = 1'b1;
                if (count == '0)
                    close_frame();
            end
        end
        else if (in_frame)
        begin
            checksum = checksum + octet_sum(data);
            push_beat(data, 1'b0, 1'b0);
            words_left = words_left - 1'b1;
            if (words_left == '0)
                close_frame();
        end
    end
    endtask

    task automatic check_beat();
        frame_beat_t want;
    begin
        if (frame_words_due.size() == 0)
            report($sformatf("unexpected beat, data %h", m_axis_tdata));
        else
        begin
            want = frame_words_due.pop_front();
            if (m_axis_tdata !== want.word)
                report($sformatf("frame_word %h, want %h", m_axis_tdata, want.word));
            if (m_axis_tlast !== want.last)
                report($sformatf("last_word %b, want %b", m_axis_tlast, want.last));
            if (m_axis_tuser[0] !== want.error)
                report($sformatf("length_error %b, want %b", m_axis_tuser[0], want.error));
        end
        beats_seen++;
    end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_words_due.delete();
            limit_len  = MAX_LENGTH_RESET;
            hop_value  = HOP_RESET;
            checksum   = '0;
            words_left = '0;
            in_frame   = 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MAX_LENGTH:  limit_len = cfg_data;
                    CFG_HOP_INITIAL: hop_value = cfg_data;
                    default: ;
                endcase
            end
            // output first: a beat leaving now cannot stem from one arriving now
            if (m_axis_tvalid && m_axis_tready)
                check_beat();
            if (s_axis_tvalid && s_axis_tready)
                assemble_reply(s_axis_tuser[0], s_axis_tdata);
        end
        pending_beats <= frame_words_due.size();
        fail_count    <= mismatches;
    end

endmodule

[bench/reply_frame_assembler_tb.sv]
// Top of the reply frame assembler bench: clock, reset, register writes and
// frame traffic under several idling patterns; verdict from reply_frame_checker.
// Depends on rfa_pkg, reply_frame_assembler and reply_frame_checker.
`timescale 1ns / 1ps

module reply_frame_assembler_tb;
    import rfa_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 42;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [0:0]            s_axis_tuser  = '0;
    logic                  m_axis_tready = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [BYTE_W-1:0]     cfg_data      = '0;

    wire logic                  s_axis_tready;
    wire logic                  m_axis_tvalid;
    wire logic [M_TDATA_W-1:0]  m_axis_tdata;
    wire logic                  m_axis_tlast;
    wire logic [0:0]            m_axis_tuser;

    int               fail_count;
    int               pending_beats;
    int               quiet_cycles   = 0;
    int               gap_pct        = 0;
    int               stall_pct      = 0;
    int               words_owed     = 0;
    logic [BYTE_W-1:0] cur_max_length = MAX_LENGTH_RESET;

    logic [BYTE_W-1:0] ml_table  [PHASES] = '{8'd255, 8'd11, 8'd10, 8'd0,
                                              8'd180, 8'd64, 8'd255, 8'd47};
    logic [BYTE_W-1:0] hop_table [PHASES] = '{8'd255, 8'd0, 8'd1, 8'd128,
                                              8'd77, 8'd13, 8'd170, 8'd85};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    reply_frame_assembler i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    reply_frame_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_beats (pending_beats)
    );

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);

    // watchdog: too long without any beat on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // valid stays high between back-to-back beats; only a gap or wait_idle lowers it
    task automatic send_beat(input logic cmd, input logic [S_TDATA_W-1:0] payload);
    begin
        while ($urandom_range(0, 99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= payload;
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    end
    endtask

    task automatic send_start(input logic [7:0] ctrl, input logic [7:0] sub,
                              input logic [15:0] mtype, input logic [15:0] src,
                              input logic [15:0] dst, input logic [15:0] seq,
                              input logic [COUNT_W-1:0] count);
    begin
        send_beat(CMD_START, {2'b00, $urandom(), count, seq, dst, src, mtype, sub, ctrl});
    end
    endtask

    task automatic send_data(input logic [WORD_W-1:0] word);
        logic [95:0] filler;
    begin
        filler = {$urandom(), $urandom(), $urandom()};
        send_beat(CMD_DATA, {2'b00, word, filler[85:0]});
    end
    endtask

    task automatic random_start(input logic [COUNT_W-1:0] count);
    begin
        send_start(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom), count);
    end
    endtask

    function automatic bit frame_fits(input int count);
        return count * 4 + int'(HEADER_BYTES) <= int'(cur_max_length);
    endfunction

    // registers only change once the block has drained
    task automatic wait_idle();
    begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_beats != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    end
    endtask

    task automatic apply_settings(input logic [BYTE_W-1:0] max_len,
                                  input logic [BYTE_W-1:0] hop);
    begin
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_LENGTH;
        cfg_data  <= max_len;
        @(posedge clk);
        cfg_index <= CFG_HOP_INITIAL;
        cfg_data  <= hop;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_max_length = max_len;
    end
    endtask

    // mostly complete frames with random content; some abandoned, oversize or stray data
    task automatic frame_traffic(input int target);
        int sent;
        int count;
        int n;
        int r;
    begin
        sent = 0;
        while (sent < target)
        begin
            if (words_owed == 0 && $urandom_range(0, 99) < 6)
                send_data($urandom());
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                    count = $urandom_range(0, 4);
                else if (r < 90)
                    count = $urandom_range(5, 15);
                else
                    count = $urandom_range(0, MAX_DATA_WORDS);
                random_start(COUNT_W'(count));
                sent++;
                if (!frame_fits(count))
                begin
                    words_owed = 0;
                    if ($urandom_range(0, 99) < 30)
                        send_data($urandom());
                end
                else
                begin
                    words_owed = count;
                    n = count;
                    if (count > 0 && $urandom_range(0, 99) < 10)
                        n = $urandom_range(0, count - 1);
                    repeat (n)
                    begin
                        send_data($urandom());
                        sent++;
                        words_owed--;
                    end
                end
            end
        end
        while (words_owed > 0)
        begin
            send_data($urandom());
            words_owed--;
        end
    end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed cases at reset settings
        send_data($urandom());
        send_start(8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 6'd0);
        send_start(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd0);
        random_start(6'd2);
        send_data(32'h0000_0000);
        send_data(32'hFFFF_FFFF);
        random_start(6'd3);
        send_data($urandom());
        random_start(6'd1);
        send_data($urandom());
        random_start(6'd62);
        send_data($urandom());
        random_start(6'd63);

        // frame length exactly at the limit, then one word over
        wait_idle();
        apply_settings(8'd19, 8'hA5);
        random_start(6'd2);
        send_data($urandom());
        send_data($urandom());
        random_start(6'd3);

        // limit below the header size refuses everything
        wait_idle();
        apply_settings(8'd10, 8'h00);
        random_start(6'd0);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 48; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 48; end
                default: begin gap_pct = 35; stall_pct = 35; end
            endcase
            if (p == 5)
                apply_settings(8'($urandom_range(12, 254)), hop_table[p]);
            else if (p == 4)
                apply_settings(ml_table[p], 8'($urandom));
            else
                apply_settings(ml_table[p], hop_table[p]);
            frame_traffic(PHASE_ITEMS);
        end

        wait_idle();
        if (fail_count == 0 && pending_beats == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
